@@ hw/rtl/pidsc_pkg.sv @@
`default_nettype none

package pidsc_pkg;

	localparam int FRACTION_BITS_DEF = 8;

	localparam int DATA_W = 16;   // measured, setpoint, drive
	localparam int ERR_W  = 17;   // setpoint - measured, exact
	localparam int GAIN_W = 16;   // unsigned Q8.8
	localparam int LIM_W  = 15;   // limit magnitude, integer units
	localparam int IDX_W  = 3;
	localparam int WR_W   = 16;   // widest register

	localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUT_LIM   = 3'd4;
	localparam logic [IDX_W-1:0] REG_INT_LIM   = 3'd5;

	typedef struct packed {
		logic              mode_incremental;
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [LIM_W-1:0]  output_limit;
		logic [LIM_W-1:0]  integral_limit;
	} cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/pidsc_stream_if.sv @@
`default_nettype none

interface pidsc_in_if import pidsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] measured;
	logic signed [DATA_W-1:0] setpoint;

	modport source (output valid, output measured, output setpoint, input ready);
	modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

interface pidsc_out_if import pidsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pidsc_cfg.sv @@
`default_nettype none

module pidsc_cfg import pidsc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [WR_W-1:0]  wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:    cfg_q.mode_incremental <= wr_data[0];
				REG_GAIN_P:  cfg_q.gain_p           <= wr_data[GAIN_W-1:0];
				REG_GAIN_I:  cfg_q.gain_i           <= wr_data[GAIN_W-1:0];
				REG_GAIN_D:  cfg_q.gain_d           <= wr_data[GAIN_W-1:0];
				REG_OUT_LIM: cfg_q.output_limit     <= wr_data[LIM_W-1:0];
				REG_INT_LIM: cfg_q.integral_limit   <= wr_data[LIM_W-1:0];
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/pidsc_calc.sv @@
`default_nettype none

module pidsc_calc import pidsc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	localparam int ACC_W = DATA_W + FRACTION_BITS
) (
	input  cfg_t                     cfg,
	input  wire logic signed [DATA_W-1:0] measured,
	input  wire logic signed [DATA_W-1:0] setpoint,
	input  wire logic signed [ERR_W-1:0]  last_err,
	input  wire logic signed [ERR_W-1:0]  older_err,
	input  wire logic signed [ACC_W-1:0]  int_sum,
	input  wire logic signed [ACC_W-1:0]  out_sum,
	output logic signed [ERR_W-1:0]       err,
	output logic signed [ACC_W-1:0]       int_next,
	output logic signed [ACC_W-1:0]       out_next,
	output logic signed [DATA_W-1:0]      drive
);

	localparam int D1_W   = ERR_W + 1;
	localparam int D2_W   = ERR_W + 2;
	localparam int K_W    = GAIN_W + 1;
	localparam int PROD_W = K_W + D2_W;
	localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 3;
	localparam logic [ACC_W-1:0] RND_MASK = ACC_W'((64'd1 << FRACTION_BITS) - 64'd1);

	function automatic logic signed [SUM_W-1:0] clamp_sym(
		input logic signed [SUM_W-1:0] v,
		input logic signed [SUM_W-1:0] lim
	);
		logic signed [SUM_W-1:0] r;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		else
			r = v;
		return r;
	endfunction

	logic signed [D1_W-1:0]   d1;
	logic signed [D2_W-1:0]   d2;
	logic signed [K_W-1:0]    kp, ki, kd;
	logic signed [D2_W-1:0]   op_p, op_i, op_d;
	logic signed [PROD_W-1:0] mp, mi, md;
	logic signed [SUM_W-1:0]  ilim, olim, int_sat, base, sum;
	logic        [ACC_W-1:0]  bias;
	logic signed [ACC_W-1:0]  rounded, shifted;

	always_comb begin
		err = ERR_W'(setpoint) - ERR_W'(measured);
		d1  = D1_W'(err) - D1_W'(last_err);
		d2  = D2_W'(err) - (D2_W'(last_err) <<< 1) + D2_W'(older_err);

		kp = $signed({1'b0, cfg.gain_p});
		ki = $signed({1'b0, cfg.gain_i});
		kd = $signed({1'b0, cfg.gain_d});

		// incremental mode feeds P and D the differences, positional feeds them e0 and e0-e1; I always takes e0
		op_p = cfg.mode_incremental ? D2_W'(d1) : D2_W'(err);
		op_i = D2_W'(err);
		op_d = cfg.mode_incremental ? d2 : D2_W'(d1);

		mp = PROD_W'(kp) * PROD_W'(op_p);
		mi = PROD_W'(ki) * PROD_W'(op_i);
		md = PROD_W'(kd) * PROD_W'(op_d);

		ilim = $signed(SUM_W'(cfg.integral_limit) << FRACTION_BITS);
		olim = $signed(SUM_W'(cfg.output_limit) << FRACTION_BITS);

		int_sat  = clamp_sym(SUM_W'(int_sum) + SUM_W'(mi), ilim);
		int_next = ACC_W'(int_sat);

		base = cfg.mode_incremental ? (SUM_W'(out_sum) + SUM_W'(mi)) : int_sat;
		sum  = base + SUM_W'(mp) + SUM_W'(md);
		out_next = ACC_W'(clamp_sym(sum, olim));

		// truncate toward zero: bias negatives before the arithmetic shift
		bias    = {ACC_W{out_next[ACC_W-1]}} & RND_MASK;
		rounded = out_next + $signed(bias);
		shifted = rounded >>> FRACTION_BITS;
		drive   = shifted[DATA_W-1:0];
	end

endmodule

`default_nettype wire

@@ hw/rtl/pid_speed_controller.sv @@
// PID speed controller, positional or incremental.
//
// sample (sink): one beat carries measured and setpoint; result (source):
// one beat carries the clamped drive value. One result beat per sample beat,
// in order.
// The sample beat is captured in an input register; from there the three
// gain multiplies, the integral clamp and the output clamp run in one pass
// and load the result register, once it is free, together with the error
// history, the output accumulator and, in positional mode only, the integral.
// Throughput is one beat per cycle while the receiver keeps result.ready
// high, set by that single registered pass through the three multipliers.
// A waiting result does not block the input register: a new sample is taken
// while the result register is full and is held there until the receiver
// takes the result. Only with both full and result.ready low is sample.ready low.
// Registers are written through wr_en/wr_index/wr_data, by the user only while
// the block holds no beat, unchecked by the block; unmapped indices are ignored.
// Reset clears all registers, history and accumulators to zero and empties
// both pipeline registers.
`default_nettype none

module pid_speed_controller import pidsc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [WR_W-1:0]  wr_data,
	pidsc_in_if.sink              sample,
	pidsc_out_if.source           result
);

	localparam int ACC_W = DATA_W + FRACTION_BITS;

	cfg_t cfg;

	logic                     valid_s1;
	logic signed [DATA_W-1:0] measured_s1, setpoint_s1;
	logic                     valid_s2;
	logic signed [DATA_W-1:0] drive_s2;

	logic signed [ERR_W-1:0]  last_err_q, older_err_q;
	logic signed [ACC_W-1:0]  int_sum_q, out_sum_q;

	logic signed [ERR_W-1:0]  err;
	logic signed [ACC_W-1:0]  int_next, out_next;
	logic signed [DATA_W-1:0] drive;

	logic s2_free, advance;

	pidsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pidsc_calc #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_calc (
		.cfg       (cfg),
		.measured  (measured_s1),
		.setpoint  (setpoint_s1),
		.last_err  (last_err_q),
		.older_err (older_err_q),
		.int_sum   (int_sum_q),
		.out_sum   (out_sum_q),
		.err       (err),
		.int_next  (int_next),
		.out_next  (out_next),
		.drive     (drive)
	);

	assign s2_free      = !valid_s2 || result.ready;
	assign advance      = valid_s1 && s2_free;
	assign sample.ready = !valid_s1 || s2_free;
	assign result.valid = valid_s2;
	assign result.drive = drive_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			measured_s1 <= sample.measured;
			setpoint_s1 <= sample.setpoint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			last_err_q  <= '0;
			older_err_q <= '0;
			int_sum_q   <= '0;
			out_sum_q   <= '0;
		end else begin
			if (s2_free)
				valid_s2 <= valid_s1;
			if (advance) begin
				older_err_q <= last_err_q;
				last_err_q  <= err;
				out_sum_q   <= out_next;
				if (!cfg.mode_incremental)
					int_sum_q <= int_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			drive_s2 <= drive;
	end

	// both registers full and receiver stalled: no new sample may be taken
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result.ready |-> !sample.ready)
		else $error("sample taken with pipeline full");

	// an item leaving the input register always lands in the result register
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item lost");

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (drive_s2 <= $signed({1'b0, cfg.output_limit}))
			&& (drive_s2 >= -$signed({1'b0, cfg.output_limit})))
		else $error("drive outside output limit");

	a_integral_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg.mode_incremental |=>
			(int_sum_q <= $signed(ACC_W'(cfg.integral_limit) << FRACTION_BITS))
			&& (int_sum_q >= -$signed(ACC_W'(cfg.integral_limit) << FRACTION_BITS)))
		else $error("integral outside integral limit");

	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> older_err_q == $past(last_err_q))
		else $error("error history not shifted");

endmodule

`default_nettype wire

@@ test/pidsc_drive_check.sv @@
`default_nettype none

module pidsc_drive_check import pidsc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [WR_W-1:0]  wr_data,
	pidsc_in_if                   sample,
	pidsc_out_if                  result,
	output int                    errors,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRACTION_BITS_DEF;

	cfg_t                     cfg;
	logic signed [ERR_W-1:0]  err_last;
	logic signed [ERR_W-1:0]  err_older;
	logic signed [23:0]       integ_acc;
	logic signed [23:0]       drive_acc;
	logic signed [DATA_W-1:0] expected_drive_q [$];
	logic signed [DATA_W-1:0] want;

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// advances the controller state by one sample and returns the drive value
	function automatic logic signed [DATA_W-1:0] next_drive(
		logic signed [DATA_W-1:0] meas,
		logic signed [DATA_W-1:0] sp
	);
		longint e0, e1, e2, kp, ki, kd, olim, ilim, integ, total;
		e0 = longint'(sp) - longint'(meas);
		e1 = longint'(err_last);
		e2 = longint'(err_older);
		kp = longint'(cfg.gain_p);
		ki = longint'(cfg.gain_i);
		kd = longint'(cfg.gain_d);
		olim = longint'(cfg.output_limit) <<< FB;
		ilim = longint'(cfg.integral_limit) <<< FB;
		err_older = ERR_W'(e1);
		err_last = ERR_W'(e0);
		if (!cfg.mode_incremental) begin
			integ = clamp_mag(longint'(integ_acc) + ki * e0, ilim);
			integ_acc = 24'(integ);
			total = kp * e0 + integ + kd * (e0 - e1);
		end else begin
			// integral untouched in this mode
			total = longint'(drive_acc) + kp * (e0 - e1) + ki * e0
				+ kd * (e0 - 2 * e1 + e2);
		end
		total = clamp_mag(total, olim);
		drive_acc = 24'(total);
		// signed division truncates toward zero
		return DATA_W'(total / (longint'(1) <<< FB));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '0;
			err_last = '0;
			err_older = '0;
			integ_acc = '0;
			drive_acc = '0;
			expected_drive_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// compare before queuing this edge's sample beat
			if (result.valid && result.ready) begin
				if (expected_drive_q.size() == 0) begin
					errors++;
					$display("%0t: drive beat with nothing expected: expected none, got %0d",
						$time, result.drive);
				end else begin
					want = expected_drive_q.pop_front();
					if (result.drive !== want) begin
						errors++;
						$display("%0t: drive mismatch: expected %0d, got %0d",
							$time, want, result.drive);
					end
				end
			end
			if (sample.valid && sample.ready)
				expected_drive_q.push_back(next_drive(sample.measured, sample.setpoint));
			if (wr_en) begin
				case (wr_index)
					REG_MODE:    cfg.mode_incremental = wr_data[0];
					REG_GAIN_P:  cfg.gain_p = wr_data[GAIN_W-1:0];
					REG_GAIN_I:  cfg.gain_i = wr_data[GAIN_W-1:0];
					REG_GAIN_D:  cfg.gain_d = wr_data[GAIN_W-1:0];
					REG_OUT_LIM: cfg.output_limit = wr_data[LIM_W-1:0];
					REG_INT_LIM: cfg.integral_limit = wr_data[LIM_W-1:0];
					default: ;
				endcase
			end
			outstanding = expected_drive_q.size();
		end
	end

endmodule

`default_nettype wire

@@ test/pid_speed_controller_test.sv @@
`default_nettype none

module pid_speed_controller_test import pidsc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [WR_W-1:0]  wr_data;
	int               send_gap_pct;
	int               recv_gap_pct;
	int               errors;
	int               outstanding;

	pidsc_in_if  sample_ch ();
	pidsc_out_if result_ch ();

	pid_speed_controller DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	pidsc_drive_check drive_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.sample      (sample_ch),
		.result      (result_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// returns at the falling edge after the beat, valid still high
	task automatic send_sample(input logic signed [DATA_W-1:0] meas,
		input logic signed [DATA_W-1:0] sp);
		while ($urandom_range(99) < send_gap_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.measured <= meas;
		sample_ch.setpoint <= sp;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	// drain everything in flight before touching the registers
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_settings(input logic [WR_W-1:0] mode, kp, ki, kd, olim, ilim);
		logic [IDX_W-1:0] idx_seq [8];
		logic [WR_W-1:0]  data_seq [8];
		idx_seq = '{REG_MODE, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_OUT_LIM,
			REG_INT_LIM, REG_UNMAPPED_LO, REG_UNMAPPED_HI};
		data_seq = '{mode, kp, ki, kd, olim, ilim, WR_W'($urandom), WR_W'($urandom)};
		foreach (idx_seq[k]) begin
			wr_en <= 1'b1;
			wr_index <= idx_seq[k];
			wr_data <= data_seq[k];
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	function automatic logic [WR_W-1:0] rand_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2, 3: return WR_W'($urandom_range(16'h0400));
			default: return WR_W'($urandom);
		endcase
	endfunction

	function automatic logic [WR_W-1:0] rand_limit();
		logic [WR_W-1:0] v;
		case ($urandom_range(7))
			0: v = '0;
			1: v = 16'h7FFF;
			2, 3: v = WR_W'($urandom_range(1, 400));
			default: v = WR_W'($urandom_range(1, 32767));
		endcase
		// top bit lies outside the limit field
		v[WR_W-1] = 1'($urandom);
		return v;
	endfunction

	// mostly a held target with the measurement hovering near it
	task automatic random_block(input int n);
		logic signed [DATA_W-1:0] target;
		int meas_i;
		int spread;
		target = DATA_W'($urandom);
		repeat (n) begin
			if ($urandom_range(4) == 0) begin
				send_sample(DATA_W'($urandom), DATA_W'($urandom));
			end else begin
				if ($urandom_range(24) == 0)
					target = DATA_W'($urandom);
				spread = ($urandom_range(9) == 0) ? 4000 : 200;
				meas_i = int'(target) + int'($urandom_range(2 * spread)) - spread;
				if (meas_i > 32767)
					meas_i = 32767;
				if (meas_i < -32768)
					meas_i = -32768;
				send_sample(DATA_W'(meas_i), target);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.measured = '0;
		sample_ch.setpoint = '0;
		result_ch.ready = 1'b0;
		send_gap_pct = 10;
		recv_gap_pct = 48;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: zero limits hold the drive at zero
		send_sample(-32768, 32767);
		send_sample(32767, -32768);

		// positional, integral clamp reached quickly
		settle();
		load_settings(16'h0000, 16'h0100, 16'h0040, 16'h0080, 16'h7FFF, 16'h0064);
		send_sample(0, 0);
		send_sample(0, 100);
		send_sample(0, 100);
		send_sample(-32768, 32767);
		send_sample(32767, -32768);
		send_sample(10, 10);
		send_sample(-5, 3);

		// switch to incremental with history carried over, full gains
		settle();
		load_settings(16'hFFFE | 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(0, 1);
		send_sample(1, 0);
		send_sample(0, 0);

		// zero limits with full gains
		settle();
		load_settings(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
		send_sample(-32768, 32767);
		send_sample(32767, -32768);
		send_sample(0, 0);

		// incremental against a one-unit output limit
		settle();
		load_settings(16'h0001, 16'h0200, 16'h0100, 16'h0000, 16'h0001, 16'h7FFF);
		send_sample(-300, 300);
		send_sample(300, -300);

		for (int blk = 0; blk < 11; blk++) begin
			if (blk < 4) begin
				send_gap_pct = 10;
				recv_gap_pct = 48;
			end else if (blk < 8) begin
				send_gap_pct = 48;
				recv_gap_pct = 10;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			settle();
			load_settings({15'($urandom), 1'($urandom)}, rand_gain(), rand_gain(),
				rand_gain(), rand_limit(), rand_limit());
			random_block(150);
		end

		settle();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
